// ===== design/hpd_pkg.sv =====
// Shared package for the Huffman prefix decoder core.
// Holds the table sizes, field widths, operation codes and the pipeline word types.
// Depends on nothing; every other file in the design folder refers to it by scoped names.
`default_nettype none

package hpd_pkg;

    // Table and code sizes
    localparam int TABLE_ENTRIES = 128;
    localparam int MAX_CODE_LEN  = 32;

    // Fixed field widths of the word ports
    localparam int OP_W     = 2;
    localparam int IN_IDX_W = 7;
    localparam int SYM_W    = 8;
    localparam int CODE_W   = 32;
    localparam int LENF_W   = 6;

    // Derived widths
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PFX_W  = MAX_CODE_LEN;
    localparam int CMP_W  = (PFX_W > CODE_W) ? PFX_W : CODE_W;
    localparam int PLEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int LCMP_W = (PLEN_W > LENF_W) ? PLEN_W : LENF_W;

    // Priority encoder grouping: lowest hit per group, then lowest group
    localparam int GRP_SIZE    = 16;
    localparam int GRP_W       = $clog2(GRP_SIZE);
    localparam int NUM_GRP     = (TABLE_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_ENTRIES = NUM_GRP * GRP_SIZE;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BIT   = 2'd1,
        OP_END   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [PFX_W-1:0]       t_pfx;
    typedef logic [PLEN_W-1:0]      t_plen;
    typedef logic [CMP_W-1:0]       t_cmp;
    typedef logic [LCMP_W-1:0]      t_lcmp;
    typedef logic [GRP_W-1:0]       t_gpos;
    typedef logic [PAD_ENTRIES-1:0] t_hits;

    // Registered input word
    typedef struct packed {
        logic                vld;
        t_op                 op;
        logic [IN_IDX_W-1:0] idx;
        logic [SYM_W-1:0]    sym;
        logic [CODE_W-1:0]   code;
        logic [LENF_W-1:0]   len;
        logic                bit_val;
    } t_item;

    // Control word carried down the pipeline after the match stage
    typedef struct packed {
        logic             load;
        logic             emit;
        logic             matched;
        logic             endf;
        logic             ovf;
        logic [SYM_W-1:0] sym;
        t_idx             idx;
    } t_ctl;

endpackage

`default_nettype wire

// ===== design/hpd_match.sv =====
// Match stage: code table cells, prefix register and parallel compare.
// Depends on hpd_pkg for widths, operation codes and the t_item and t_ctl types.
`default_nettype none

module hpd_match (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hpd_pkg::t_item i_item,
    output hpd_pkg::t_ctl      o_ctl,
    output hpd_pkg::t_hits     o_hits
);

    logic [hpd_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic [hpd_pkg::TABLE_ENTRIES-1:0] n_valid;
    logic [hpd_pkg::CODE_W-1:0]        r_code [hpd_pkg::TABLE_ENTRIES];
    logic [hpd_pkg::LENF_W-1:0]        r_len  [hpd_pkg::TABLE_ENTRIES];

    hpd_pkg::t_pfx  r_pfx;
    hpd_pkg::t_pfx  n_pfx;
    hpd_pkg::t_plen r_plen;
    hpd_pkg::t_plen n_plen;

    logic [hpd_pkg::TABLE_ENTRIES-1:0] hit;
    logic                              any_hit;
    logic                              idx_ok;
    logic                              is_load;
    logic                              full;
    hpd_pkg::t_idx                     widx;
    hpd_pkg::t_ctl                     r_ctl;
    hpd_pkg::t_ctl                     n_ctl;
    hpd_pkg::t_hits                    r_hits;

    // Compare the prefix against every cell at once
    always_comb begin
        for (int i = 0; i < hpd_pkg::TABLE_ENTRIES; i++) begin
            hit[i] = r_valid[i] && (r_len[i] != '0)
                && (hpd_pkg::t_lcmp'(r_len[i]) == hpd_pkg::t_lcmp'(r_plen))
                && (hpd_pkg::t_cmp'(r_code[i]) == hpd_pkg::t_cmp'(r_pfx));
        end
        any_hit = |hit;
    end

    assign idx_ok  = int'(i_item.idx) < hpd_pkg::TABLE_ENTRIES;
    assign widx    = hpd_pkg::t_idx'(i_item.idx);
    assign is_load = i_item.vld && (i_item.op == hpd_pkg::OP_LOAD) && idx_ok;
    assign full    = r_plen >= hpd_pkg::t_plen'(hpd_pkg::MAX_CODE_LEN);

    always_comb begin
        n_valid = r_valid;
        n_pfx   = r_pfx;
        n_plen  = r_plen;

        n_ctl         = '0;
        n_ctl.load    = is_load;
        n_ctl.sym     = i_item.sym;
        n_ctl.idx     = widx;
        n_ctl.endf    = i_item.op == hpd_pkg::OP_END;
        n_ctl.matched = any_hit;

        if (i_item.vld) begin
            case (i_item.op)
                hpd_pkg::OP_LOAD: begin
                    if (idx_ok) begin
                        n_valid[widx] = 1'b1;
                    end
                end
                hpd_pkg::OP_BIT: begin
                    if (any_hit) begin
                        n_ctl.emit = 1'b1;
                        n_pfx      = hpd_pkg::t_pfx'(i_item.bit_val);
                        n_plen     = hpd_pkg::t_plen'(1);
                    end else if (full) begin
                        // prefix too long for any code: drop it and the new bit
                        n_ctl.emit = 1'b1;
                        n_ctl.ovf  = 1'b1;
                        n_pfx      = '0;
                        n_plen     = '0;
                    end else begin
                        n_pfx  = {r_pfx[hpd_pkg::PFX_W-2:0], i_item.bit_val};
                        n_plen = r_plen + hpd_pkg::t_plen'(1);
                    end
                end
                hpd_pkg::OP_END: begin
                    n_ctl.emit = 1'b1;
                    n_pfx      = '0;
                    n_plen     = '0;
                end
                hpd_pkg::OP_CLEAR: begin
                    n_valid = '0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    // Strobes and prefix take the reset; the payload of the control word does not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pfx       <= '0;
            r_plen      <= '0;
            r_ctl.load  <= 1'b0;
            r_ctl.emit  <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_pfx       <= n_pfx;
            r_plen      <= n_plen;
            r_ctl.load  <= n_ctl.load;
            r_ctl.emit  <= n_ctl.emit;
        end
        r_ctl.matched <= n_ctl.matched;
        r_ctl.endf    <= n_ctl.endf;
        r_ctl.ovf     <= n_ctl.ovf;
        r_ctl.sym     <= n_ctl.sym;
        r_ctl.idx     <= n_ctl.idx;
        r_hits        <= hpd_pkg::t_hits'(hit);
    end

    // Cell contents carry no reset
    always_ff @(posedge i_clk) begin
        if (is_load) begin
            r_code[widx] <= i_item.code;
            r_len[widx]  <= i_item.len;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_hits = r_hits;

endmodule

`default_nettype wire

// ===== design/hpd_prio.sv =====
// Two stage priority encoder: lowest hit inside each group, then lowest group.
// Depends on hpd_pkg for the grouping constants and the t_ctl type.
`default_nettype none

module hpd_prio (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hpd_pkg::t_ctl  i_ctl,
    input  wire hpd_pkg::t_hits i_hits,
    output hpd_pkg::t_ctl       o_ctl,
    output hpd_pkg::t_idx       o_idx
);

    logic [hpd_pkg::NUM_GRP-1:0] r_gany;
    logic [hpd_pkg::NUM_GRP-1:0] n_gany;
    hpd_pkg::t_gpos              r_gpos [hpd_pkg::NUM_GRP];
    hpd_pkg::t_gpos              n_gpos [hpd_pkg::NUM_GRP];
    hpd_pkg::t_ctl               r_ctl2;
    hpd_pkg::t_ctl               r_ctl3;
    hpd_pkg::t_idx               r_idx;
    hpd_pkg::t_idx               n_idx;

    // Lowest set bit in each group; scan downwards so the lowest wins
    always_comb begin
        for (int g = 0; g < hpd_pkg::NUM_GRP; g++) begin
            n_gany[g] = 1'b0;
            n_gpos[g] = '0;
            for (int j = hpd_pkg::GRP_SIZE - 1; j >= 0; j--) begin
                if (i_hits[g * hpd_pkg::GRP_SIZE + j]) begin
                    n_gany[g] = 1'b1;
                    n_gpos[g] = hpd_pkg::t_gpos'(j);
                end
            end
        end
    end

    // Lowest group with a hit
    always_comb begin
        n_idx = '0;
        for (int g = hpd_pkg::NUM_GRP - 1; g >= 0; g--) begin
            if (r_gany[g]) begin
                n_idx = hpd_pkg::t_idx'(g * hpd_pkg::GRP_SIZE + int'(r_gpos[g]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2.load <= 1'b0;
            r_ctl2.emit <= 1'b0;
            r_ctl3.load <= 1'b0;
            r_ctl3.emit <= 1'b0;
        end else begin
            r_ctl2.load <= i_ctl.load;
            r_ctl2.emit <= i_ctl.emit;
            r_ctl3.load <= r_ctl2.load;
            r_ctl3.emit <= r_ctl2.emit;
        end
        r_ctl2.matched <= i_ctl.matched;
        r_ctl2.endf    <= i_ctl.endf;
        r_ctl2.ovf     <= i_ctl.ovf;
        r_ctl2.sym     <= i_ctl.sym;
        r_ctl2.idx     <= i_ctl.idx;
        r_ctl3.matched <= r_ctl2.matched;
        r_ctl3.endf    <= r_ctl2.endf;
        r_ctl3.ovf     <= r_ctl2.ovf;
        r_ctl3.sym     <= r_ctl2.sym;
        r_ctl3.idx     <= r_ctl2.idx;
    end

    always_ff @(posedge i_clk) begin
        r_gany         <= n_gany;
        r_gpos         <= n_gpos;
        r_idx          <= n_idx;
    end

    assign o_ctl = r_ctl3;
    assign o_idx = r_idx;

endmodule

`default_nettype wire

// ===== design/hpd_symram.sv =====
// Symbol memory: one write port for load words, one registered read port.
// Depends on hpd_pkg for the table depth and the t_ctl type.
`default_nettype none

module hpd_symram (
    input  wire logic                      i_clk,
    input  wire hpd_pkg::t_ctl             i_ctl,
    input  wire hpd_pkg::t_idx             i_rd_idx,
    output logic [hpd_pkg::SYM_W-1:0]      o_rd_sym
);

    logic [hpd_pkg::SYM_W-1:0] mem [hpd_pkg::TABLE_ENTRIES];
    logic [hpd_pkg::SYM_W-1:0] r_rd;

    // Writes arrive in word order, so a read sees the symbol current at match time
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            mem[i_ctl.idx] <= i_ctl.sym;
        end
        r_rd <= mem[i_rd_idx];
    end

    assign o_rd_sym = r_rd;

endmodule

`default_nettype wire

// ===== design/huffman_prefix_decoder_core.sv =====
// Top level of the Huffman prefix decoder: input register, match stage,
// priority encoder, symbol memory and result register.
// Depends on hpd_pkg, hpd_match, hpd_prio and hpd_symram.
//
//  channel  | handshake           | word ports
//  ---------+---------------------+-----------------------------------------------
//  input    | start, busy         | i_operation, i_entry_index, i_entry_symbol,
//           |                     | i_entry_code, i_entry_length, i_bit_value
//  result   | o_valid (strobe)    | o_decoded_symbol, o_matched, o_end_flush,
//           |                     | o_prefix_overflow
//
// One word is taken in every cycle: busy is high only while reset is held.
// A result leaves on o_valid for one cycle; between its word and the result lie
// the input register, the parallel compare of the prefix against all table
// cells, the two priority encoder stages and the symbol read.
// The prefix loop (compare, any hit, prefix update) is combinational back into the prefix register.
// Reset clears the table valid bits, the prefix and every stage's strobe.
// The receiver cannot stall the result side, so nothing here back-pressures.
`default_nettype none

module huffman_prefix_decoder_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [hpd_pkg::OP_W-1:0]     i_operation,
    input  wire logic [hpd_pkg::IN_IDX_W-1:0] i_entry_index,
    input  wire logic [hpd_pkg::SYM_W-1:0]    i_entry_symbol,
    input  wire logic [hpd_pkg::CODE_W-1:0]   i_entry_code,
    input  wire logic [hpd_pkg::LENF_W-1:0]   i_entry_length,
    input  wire logic                         i_bit_value,
    output logic                              o_valid,
    output logic [hpd_pkg::SYM_W-1:0]         o_decoded_symbol,
    output logic                              o_matched,
    output logic                              o_end_flush,
    output logic                              o_prefix_overflow
);

    localparam int LAT = 5;

    hpd_pkg::t_item            r_item;
    hpd_pkg::t_ctl             s1_ctl;
    hpd_pkg::t_hits            s1_hits;
    hpd_pkg::t_ctl             s3_ctl;
    hpd_pkg::t_idx             s3_idx;
    logic [hpd_pkg::SYM_W-1:0] rd_sym;
    logic                      r_out_emit;
    logic                      r_out_matched;
    logic                      r_out_endf;
    logic                      r_out_ovf;

    // Hold off words only during reset
    assign busy = !i_rst_n;

    // Input register: capture the word, flagged valid by start; the payload carries no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else begin
            r_item.vld <= start;
        end
        r_item.op      <= hpd_pkg::t_op'(i_operation);
        r_item.idx     <= i_entry_index;
        r_item.sym     <= i_entry_symbol;
        r_item.code    <= i_entry_code;
        r_item.len     <= i_entry_length;
        r_item.bit_val <= i_bit_value;
    end

    // Compare the prefix against the table, update prefix and cells
    hpd_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_item),
        .o_ctl   (s1_ctl),
        .o_hits  (s1_hits)
    );

    // Pick the lowest matching index
    hpd_prio u_prio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s1_ctl),
        .i_hits  (s1_hits),
        .o_ctl   (s3_ctl),
        .o_idx   (s3_idx)
    );

    // Read the symbol of the winning entry; load words write it here
    hpd_symram u_symram (
        .i_clk    (i_clk),
        .i_ctl    (s3_ctl),
        .i_rd_idx (s3_idx),
        .o_rd_sym (rd_sym)
    );

    // Result register, aligned with the registered memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_emit <= 1'b0;
        end else begin
            r_out_emit <= s3_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_matched <= s3_ctl.matched;
        r_out_endf    <= s3_ctl.endf;
        r_out_ovf     <= s3_ctl.ovf;
    end

    assign o_valid           = r_out_emit;
    assign o_matched         = r_out_matched;
    assign o_end_flush       = r_out_endf;
    assign o_prefix_overflow = r_out_ovf;
    // Drop the memory word when nothing matched
    assign o_decoded_symbol  = r_out_matched ? rd_sym : '0;

    // A result never claims both a match and an overflow
    a_match_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_matched && o_prefix_overflow))
        else $error("result flags both a match and an overflow");

    // An end word always gives a flush result after the pipeline depth
    a_end_gives_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == hpd_pkg::OP_END))
        |-> ##LAT (o_valid && o_end_flush && !o_prefix_overflow))
        else $error("end word did not give a flush result");

    // Load and clear words never give a result
    a_silent_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_operation == hpd_pkg::OP_LOAD)
            || (i_operation == hpd_pkg::OP_CLEAR)))
        |-> ##LAT !o_valid)
        else $error("load or clear word gave a result");

endmodule

`default_nettype wire
